// File: hdl/sat_pkg.sv
// Shared constants and types for the summed-area table block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sat_pkg;

    localparam int MAX_ROWS     = 256;
    localparam int MAX_COLS     = 256;
    localparam int ELEMENT_BITS = 18;
    localparam int ROW_BITS     = $clog2(MAX_ROWS);
    localparam int COL_BITS     = $clog2(MAX_COLS);
    localparam int ADDR_BITS    = ROW_BITS + COL_BITS;
    localparam int DIM_BITS     = 9;
    localparam int COORD_BITS   = 8;
    localparam int RUN_BITS     = 27;
    localparam int SUM_BITS     = 35;
    localparam int STATUS_BITS  = 2;
    localparam int PADDR_BITS   = 3;
    localparam int PDATA_BITS   = 32;

    localparam logic [STATUS_BITS-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_BAD_COORD  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_LOADED = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef struct packed {
        logic [DIM_BITS-1:0] rows;
        logic [DIM_BITS-1:0] cols;
        logic                restart;
    } sat_cfg_t;

    typedef struct packed {
        logic                 en;
        logic                 we;
        logic [ADDR_BITS-1:0] addr;
        logic [SUM_BITS-1:0]  wdata;
    } sat_mem_req_t;

endpackage

`default_nettype wire

// File: hdl/sat_if.sv
// Valid/ready channel interfaces for query and load items and for results.
// Depends on sat_pkg for field widths.
`default_nettype none

interface sat_in_if import sat_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic signed [ELEMENT_BITS-1:0] element_value;
    logic [COORD_BITS-1:0]          top_row;
    logic [COORD_BITS-1:0]          left_col;
    logic [COORD_BITS-1:0]          bottom_row;
    logic [COORD_BITS-1:0]          right_col;

    modport source (output valid, kind, element_value, top_row, left_col,
                    bottom_row, right_col, input ready);
    modport sink (input valid, kind, element_value, top_row, left_col,
                  bottom_row, right_col, output ready);
endinterface

interface sat_out_if import sat_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SUM_BITS-1:0] region_sum;
    logic [STATUS_BITS-1:0]     status;

    modport source (output valid, region_sum, status, input ready);
    modport sink (input valid, region_sum, status, output ready);
endinterface

`default_nettype wire

// File: hdl/summed_area_table_region_sum.sv
// Top level of the summed-area table block: register port, sequencer, memory.
// Depends on sat_pkg, sat_if.sv, sat_cfg, sat_mem and sat_ctrl.
//
// Usage. Items enter on the req channel (valid/ready). A load item (kind 0)
// carries the next matrix element in raster order; the block adds it to the
// running row sum plus the table entry above and stores the result. Loads
// after rows_in_use * cols_in_use elements are dropped. A query item (kind 1)
// gives two corners and yields one item on the rsp channel: the rectangle sum
// and a status (ok, bad coordinates, or table not yet fully loaded).
// Sequencing. All table state sits in one single-port memory with a registered
// read, so each item runs through a sequencer: a load goes through accept, the
// read of the entry above and the write; a dropped load ends at acceptance; a
// rejected query goes straight to the result state; a valid query reads its
// four corners one after another through the single memory port. The next
// item is accepted only once the sequencer is back in its idle state.
// Stalls. Results sit in an output register; while rsp.ready is low the block
// still accepts and processes loads and holds a finished query result in the
// sequencer until the output register frees up.
// Reset. rst_n clears the loader counters and sets both dimensions to 256.
// The table memory is not cleared; writing rows_in_use or cols_in_use (byte
// address 0 and 4 of the APB port) restarts loading from row 0.
`default_nettype none

module summed_area_table_region_sum import sat_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    sat_in_if.sink                     req,
    sat_out_if.source                  rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [PDATA_BITS-1:0] pwdata,
    output logic      [PDATA_BITS-1:0] prdata,
    output logic                       pready
);

    sat_cfg_t            cfg;
    sat_mem_req_t        mem_req;
    logic [SUM_BITS-1:0] mem_rdata;

    // Dimension registers behind the APB port.
    sat_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The prefix table itself, one entry per matrix position.
    sat_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // Load and query sequencing, including the output register.
    sat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (cfg),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// File: hdl/sat_cfg.sv
// APB-style register block holding the table dimensions.
// Depends on sat_pkg; raises a restart pulse on every register write.
`default_nettype none

module sat_cfg import sat_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [PDATA_BITS-1:0] pwdata,
    output logic      [PDATA_BITS-1:0] prdata,
    output logic                       pready,
    output sat_cfg_t                   cfg
);

    logic [DIM_BITS-1:0] rows_reg, rows_next;
    logic [DIM_BITS-1:0] cols_reg, cols_next;
    logic                wr_en;
    logic [DIM_BITS-1:0] raw;
    logic [DIM_BITS-1:0] rows_clamped;
    logic [DIM_BITS-1:0] cols_clamped;

    assign wr_en  = psel & penable & pwrite;
    assign raw    = pwdata[DIM_BITS-1:0];
    assign pready = 1'b1;

    // Zero reads as one; anything above the maximum reads as the maximum.
    always_comb
    begin
        rows_clamped = raw;
        if (raw == '0)
        begin
            rows_clamped = DIM_BITS'(1);
        end
        else if (raw > DIM_BITS'(MAX_ROWS))
        begin
            rows_clamped = DIM_BITS'(MAX_ROWS);
        end
        cols_clamped = raw;
        if (raw == '0)
        begin
            cols_clamped = DIM_BITS'(1);
        end
        else if (raw > DIM_BITS'(MAX_COLS))
        begin
            cols_clamped = DIM_BITS'(MAX_COLS);
        end
    end

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (wr_en)
        begin
            if (paddr[2] == REG_ROWS)
            begin
                rows_next = rows_clamped;
            end
            else
            begin
                cols_next = cols_clamped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DIM_BITS'(MAX_ROWS);
            cols_reg <= DIM_BITS'(MAX_COLS);
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    assign prdata = (paddr[2] == REG_COLS) ? PDATA_BITS'(cols_reg) : PDATA_BITS'(rows_reg);

    // The restart acts at the write edge itself, together with the new size.
    assign cfg.rows    = rows_reg;
    assign cfg.cols    = cols_reg;
    assign cfg.restart = wr_en;

endmodule

`default_nettype wire

// File: hdl/sat_mem.sv
// Single-port synchronous table memory with a registered read.
// Depends on sat_pkg for depth and entry width.
`default_nettype none

module sat_mem import sat_pkg::*;
(
    input  wire logic          clk,
    input  wire sat_mem_req_t  req,
    output logic [SUM_BITS-1:0] rdata
);

    logic [SUM_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];
    logic [SUM_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem[req.addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/sat_ctrl.sv
// Sequencer for loads and region queries around the table memory.
// Depends on sat_pkg and the channel interfaces in sat_if.sv.
`default_nettype none

module sat_ctrl import sat_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    sat_in_if.sink              req,
    sat_out_if.source           rsp,
    input  wire sat_cfg_t       cfg,
    output sat_mem_req_t        mem_req,
    input  wire logic [SUM_BITS-1:0] mem_rdata
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_LD_WR  = 4'd2;
    localparam logic [3:0] S_Q0     = 4'd3;
    localparam logic [3:0] S_Q1     = 4'd4;
    localparam logic [3:0] S_Q2     = 4'd5;
    localparam logic [3:0] S_Q3     = 4'd6;
    localparam logic [3:0] S_Q4     = 4'd7;
    localparam logic [3:0] S_RESULT = 4'd8;

    logic [3:0]                 state_reg, state_next;
    logic [DIM_BITS-1:0]        load_row_reg, load_row_next;
    logic [COL_BITS-1:0]        load_col_reg, load_col_next;
    logic                       full_reg, full_next;
    logic signed [RUN_BITS-1:0] run_reg, run_next;
    logic [ELEMENT_BITS-1:0]    elem_reg, elem_next;
    logic [COORD_BITS-1:0]      r1_reg, r1_next, c1_reg, c1_next;
    logic [COORD_BITS-1:0]      r2_reg, r2_next, c2_reg, c2_next;
    logic [SUM_BITS-1:0]        sum_reg, sum_next;
    logic [STATUS_BITS-1:0]     status_reg, status_next;
    logic                       out_valid_reg, out_valid_next;
    logic [SUM_BITS-1:0]        out_sum_reg, out_sum_next;
    logic [STATUS_BITS-1:0]     out_status_reg, out_status_next;

    logic                       accept;
    logic                       bad_coord;
    logic signed [RUN_BITS-1:0] elem_ext;
    logic [SUM_BITS-1:0]        above;
    logic [DIM_BITS-1:0]        col_inc;
    logic [DIM_BITS-1:0]        row_inc;
    logic [DIM_BITS-1:0]        row_dec;
    logic [COORD_BITS-1:0]      r1_dec, c1_dec;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid & req.ready;

    assign bad_coord = (req.top_row > req.bottom_row) || (req.left_col > req.right_col)
                    || ({1'b0, req.bottom_row} >= cfg.rows)
                    || ({1'b0, req.right_col} >= cfg.cols);

    assign elem_ext = {{(RUN_BITS-ELEMENT_BITS){elem_reg[ELEMENT_BITS-1]}}, elem_reg};
    assign above    = (load_row_reg == '0) ? '0 : mem_rdata;
    assign col_inc  = {1'b0, load_col_reg} + DIM_BITS'(1);
    assign row_inc  = load_row_reg + DIM_BITS'(1);
    assign row_dec  = load_row_reg - DIM_BITS'(1);
    assign r1_dec   = r1_reg - COORD_BITS'(1);
    assign c1_dec   = c1_reg - COORD_BITS'(1);

    // Memory port: one read or one write per cycle, addressed by state.
    always_comb
    begin
        mem_req.en    = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.addr  = {load_row_reg[ROW_BITS-1:0], load_col_reg};
        mem_req.wdata = SUM_BITS'(run_reg) + above;
        case (state_reg)
            S_LOAD:
            begin
                mem_req.en   = (load_row_reg != '0);
                mem_req.addr = {row_dec[ROW_BITS-1:0], load_col_reg};
            end
            S_LD_WR:
            begin
                mem_req.en = 1'b1;
                mem_req.we = 1'b1;
            end
            S_Q0:
            begin
                mem_req.en   = 1'b1;
                mem_req.addr = {r2_reg, c2_reg};
            end
            S_Q1:
            begin
                mem_req.en   = 1'b1;
                mem_req.addr = {r2_reg, c1_dec};
            end
            S_Q2:
            begin
                mem_req.en   = 1'b1;
                mem_req.addr = {r1_dec, c2_reg};
            end
            S_Q3:
            begin
                mem_req.en   = 1'b1;
                mem_req.addr = {r1_dec, c1_dec};
            end
            default:
            begin
                mem_req.en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        load_row_next   = load_row_reg;
        load_col_next   = load_col_reg;
        full_next       = full_reg;
        run_next        = run_reg;
        elem_next       = elem_reg;
        r1_next         = r1_reg;
        c1_next         = c1_reg;
        r2_next         = r2_reg;
        c2_next         = c2_reg;
        sum_next        = sum_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg & ~rsp.ready;
        out_sum_next    = out_sum_reg;
        out_status_next = out_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    elem_next = req.element_value;
                    r1_next   = req.top_row;
                    c1_next   = req.left_col;
                    r2_next   = req.bottom_row;
                    c2_next   = req.right_col;
                    if (req.kind == KIND_LOAD)
                    begin
                        if (!full_reg)
                        begin
                            state_next = S_LOAD;
                        end
                    end
                    else if (!full_reg)
                    begin
                        sum_next    = '0;
                        status_next = STATUS_NOT_LOADED;
                        state_next  = S_RESULT;
                    end
                    else if (bad_coord)
                    begin
                        sum_next    = '0;
                        status_next = STATUS_BAD_COORD;
                        state_next  = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_Q0;
                    end
                end
            end
            S_LOAD:
            begin
                run_next   = run_reg + elem_ext;
                state_next = S_LD_WR;
            end
            S_LD_WR:
            begin
                state_next = S_IDLE;
                if (col_inc >= cfg.cols)
                begin
                    load_col_next = '0;
                    run_next      = '0;
                    load_row_next = row_inc;
                    if (row_inc >= cfg.rows)
                    begin
                        full_next = 1'b1;
                    end
                end
                else
                begin
                    load_col_next = col_inc[COL_BITS-1:0];
                end
            end
            S_Q0:
            begin
                state_next = S_Q1;
            end
            S_Q1:
            begin
                sum_next   = mem_rdata;
                state_next = S_Q2;
            end
            S_Q2:
            begin
                sum_next   = sum_reg - ((c1_reg == '0) ? '0 : mem_rdata);
                state_next = S_Q3;
            end
            S_Q3:
            begin
                sum_next   = sum_reg - ((r1_reg == '0) ? '0 : mem_rdata);
                state_next = S_Q4;
            end
            S_Q4:
            begin
                sum_next    = sum_reg
                            + ((r1_reg == '0 || c1_reg == '0) ? '0 : mem_rdata);
                status_next = STATUS_OK;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_sum_next    = sum_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Configuration writes must arrive only while idle; the block does not enforce this. They restart loading.
        if (cfg.restart)
        begin
            load_row_next = '0;
            load_col_next = '0;
            run_next      = '0;
            full_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            full_reg      <= 1'b0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_row_reg  <= load_row_next;
            load_col_reg  <= load_col_next;
            full_reg      <= full_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elem_reg       <= elem_next;
        r1_reg         <= r1_next;
        c1_reg         <= c1_next;
        r2_reg         <= r2_next;
        c2_reg         <= c2_next;
        sum_reg        <= sum_next;
        status_reg     <= status_next;
        out_sum_reg    <= out_sum_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.region_sum = out_sum_reg;
    assign rsp.status     = out_status_reg;

`ifndef SYNTHESIS
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> !full_reg)
        else $error("table write while the table is full");

    a_query_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_Q0 || state_reg == S_Q1 || state_reg == S_Q2
         || state_reg == S_Q3 || state_reg == S_Q4) |-> full_reg)
        else $error("table read for a query before the table is full");

    a_full_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full_reg) |-> $past(state_reg) == S_LD_WR)
        else $error("table marked full without a final load write");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && out_valid_reg && !rsp.ready) |=> state_reg == S_RESULT)
        else $error("result left its holding state while the output was stalled");
`endif

endmodule

`default_nettype wire

// File: verif/summed_area_table_region_sum_checker.sv
// Scoreboard for the summed-area table block: follows register writes and loads,
// predicts every query result and checks the rsp channel against it.
// Depends on sat_pkg and the valid/ready interfaces in sat_if.sv.
`timescale 1ns / 1ps

module summed_area_table_region_sum_checker import sat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sat_in_if                     req,
    sat_out_if                    rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output int                    error_count,
    output int                    results_owed
);

    localparam int REPORT_LIMIT = 10;
    localparam logic [PADDR_BITS-1:0] ROWS_ADDR = PADDR_BITS'({REG_ROWS, 2'b00});
    localparam logic [PADDR_BITS-1:0] COLS_ADDR = PADDR_BITS'({REG_COLS, 2'b00});

    typedef struct packed {
        logic signed [SUM_BITS-1:0] region_sum;
        logic [STATUS_BITS-1:0]     status;
    } region_result_t;

    region_result_t expected_regions[$];
    longint         area_table [MAX_ROWS*MAX_COLS];
    longint         row_sum;
    int             fill_row;
    int             fill_col;
    int             rows_used;
    int             cols_used;
    bit             table_full;
    int             errors_seen = 0;

    // Only the low register bits count; zero means one, oversize means the maximum.
    function automatic int dim_from_word(input logic [PDATA_BITS-1:0] word, input int limit);
        int dim;
        dim = int'(word[DIM_BITS-1:0]);
        if (dim == 0)
            dim = 1;
        if (dim > limit)
            dim = limit;
        return dim;
    endfunction

    function automatic void restart_fill();
        row_sum    = 0;
        fill_row   = 0;
        fill_col   = 0;
        table_full = 1'b0;
    endfunction

    // Each entry is the running sum of its row plus the entry above it.
    function automatic void store_element(input longint value);
        longint above;
        above = (fill_row == 0) ? 0 : area_table[(fill_row - 1) * MAX_COLS + fill_col];
        row_sum += value;
        area_table[fill_row * MAX_COLS + fill_col] = row_sum + above;
        fill_col++;
        if (fill_col >= cols_used) begin
            fill_col = 0;
            row_sum  = 0;
            fill_row++;
            if (fill_row >= rows_used)
                table_full = 1'b1;
        end
    endfunction

    function automatic region_result_t predict_region(input int tr, input int lc,
                                                       input int br, input int rc);
        region_result_t res;
        longint         total;
        res.region_sum = '0;
        if (!table_full) begin
            res.status = STATUS_NOT_LOADED;
        end
        else if (tr > br || lc > rc || br >= rows_used || rc >= cols_used) begin
            res.status = STATUS_BAD_COORD;
        end
        else begin
            total = area_table[br * MAX_COLS + rc];
            if (lc > 0)
                total -= area_table[br * MAX_COLS + lc - 1];
            if (tr > 0)
                total -= area_table[(tr - 1) * MAX_COLS + rc];
            if (tr > 0 && lc > 0)
                total += area_table[(tr - 1) * MAX_COLS + lc - 1];
            res.region_sum = total[SUM_BITS-1:0];
            res.status     = STATUS_OK;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        region_result_t seen;
        region_result_t want;
        if (!rst_n) begin
            expected_regions.delete();
            rows_used = MAX_ROWS;
            cols_used = MAX_COLS;
            restart_fill();
            error_count  <= 0;
            results_owed <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ROWS_ADDR) begin
                    rows_used = dim_from_word(pwdata, MAX_ROWS);
                    restart_fill();
                end
                else if (paddr == COLS_ADDR) begin
                    cols_used = dim_from_word(pwdata, MAX_COLS);
                    restart_fill();
                end
            end

            if (req.valid === 1'b1 && req.ready === 1'b1) begin
                if (req.kind == KIND_LOAD) begin
                    if (!table_full)
                        store_element(longint'(req.element_value));
                end
                else begin
                    expected_regions.push_back(predict_region(int'(req.top_row),
                        int'(req.left_col), int'(req.bottom_row), int'(req.right_col)));
                end
            end

            if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
                seen.region_sum = rsp.region_sum;
                seen.status     = rsp.status;
                if (expected_regions.size() == 0) begin
                    errors_seen++;
                    if (errors_seen <= REPORT_LIMIT)
                        $display("%0t: unexpected result: sum %0d status %0d",
                                 $realtime, seen.region_sum, seen.status);
                end
                else begin
                    want = expected_regions.pop_front();
                    if (seen.region_sum !== want.region_sum || seen.status !== want.status) begin
                        errors_seen++;
                        if (errors_seen <= REPORT_LIMIT)
                            $display("%0t: region mismatch: expected sum %0d status %0d, got sum %0d status %0d",
                                     $realtime, want.region_sum, want.status,
                                     seen.region_sum, seen.status);
                    end
                end
            end

            error_count  <= errors_seen;
            results_owed <= expected_regions.size();
        end
    end

endmodule

// File: verif/summed_area_table_region_sum_tb.sv
// Top of the summed-area table testbench: clock, reset, stimulus and verdict.
// Depends on sat_pkg, sat_if.sv, the block itself and the region sum checker.
`timescale 1ns / 1ps

module summed_area_table_region_sum_tb;
    import sat_pkg::*;

    localparam int     CLK_HALF_NS   = 5;
    localparam int     ITEM_TARGET   = 1600;
    localparam int     MAX_GAP       = 10;
    localparam int     MAX_BURST     = 24;
    // Longest sequencer run is a query plus a held result; this covers it with margin.
    localparam int     SETTLE_CYCLES = 12;
    localparam longint RUN_LIMIT_NS  = 25_000_000;
    localparam int     COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int     FEED_ROWS     = 8;
    localparam int     FEED_COLS     = 8;

    localparam logic [ELEMENT_BITS-1:0] ELEM_MIN = {1'b1, {(ELEMENT_BITS-1){1'b0}}};
    localparam logic [ELEMENT_BITS-1:0] ELEM_MAX = {1'b0, {(ELEMENT_BITS-1){1'b1}}};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    int error_count;
    int results_owed;

    sat_in_if  req_ch ();
    sat_out_if rsp_ch ();

    summed_area_table_region_sum dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The checker watches both channels and the register port on its own and
    // reports back how many results failed and how many are still owed.
    summed_area_table_region_sum_checker region_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .error_count  (error_count),
        .results_owed (results_owed)
    );

    always
    begin
        #(CLK_HALF_NS) clk = 1'b1;
        #(CLK_HALF_NS) clk = 1'b0;
    end

    // Stimulus bookkeeping. The top knows the shape it programmed, so it can
    // build well-formed loads and in-range rectangles without predicting sums.
    int cur_rows    = MAX_ROWS;
    int cur_cols    = MAX_COLS;
    int loads_done  = 0;
    int items_sent  = 0;
    int queries_sent = 0;
    int shapes_tried = 0;
    int burst_left  = 0;
    bit steady_feed = 1'b0;

    // Receiver: mostly ready, with short random stalls and now and then a long
    // calm stretch in which it never stalls.
    int stall_left = 0;
    int calm_left  = 0;

    always @(posedge clk)
    begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end
        else if (calm_left != 0) begin
            rsp_ch.ready <= 1'b1;
            calm_left    <= calm_left - 1;
        end
        else if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else begin
            rsp_ch.ready <= 1'b1;
            case ($urandom_range(0, 31))
                0:             calm_left  <= $urandom_range(50, 300);
                1, 2, 3, 4, 5: stall_left <= $urandom_range(1, 12);
                default:       ;
            endcase
        end
    end

    // One item on the req channel. Valid stays high inside a burst; when a
    // burst runs out the sender drops valid for a random gap, unless feeding steadily.
    task automatic offer_item(input logic kind, input logic [ELEMENT_BITS-1:0] value,
                              input logic [COORD_BITS-1:0] tr, input logic [COORD_BITS-1:0] lc,
                              input logic [COORD_BITS-1:0] br, input logic [COORD_BITS-1:0] rc);
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= kind;
        req_ch.element_value <= value;
        req_ch.top_row       <= tr;
        req_ch.left_col      <= lc;
        req_ch.bottom_row    <= br;
        req_ch.right_col     <= rc;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        if (!steady_feed) begin
            if (burst_left == 0) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, MAX_GAP))
                    @(posedge clk);
                burst_left = $urandom_range(1, MAX_BURST);
            end
            else begin
                burst_left--;
            end
        end
    endtask

    // Loads carry random corner fields, which the block must ignore. Loads past
    // a full table are dropped by the block and are not counted.
    task automatic push_element(input logic [ELEMENT_BITS-1:0] value);
        offer_item(KIND_LOAD, value, COORD_BITS'($urandom), COORD_BITS'($urandom),
                   COORD_BITS'($urandom), COORD_BITS'($urandom));
        if (loads_done < cur_rows * cur_cols)
            items_sent++;
        loads_done++;
    endtask

    task automatic ask_region(input int tr, input int lc, input int br, input int rc);
        offer_item(KIND_QUERY, ELEMENT_BITS'($urandom), COORD_BITS'(tr), COORD_BITS'(lc),
                   COORD_BITS'(br), COORD_BITS'(rc));
        items_sent++;
        queries_sent++;
    endtask

    function automatic logic [ELEMENT_BITS-1:0] rand_element();
        case ($urandom_range(0, 7))
            0:       return ELEM_MIN;
            1:       return ELEM_MAX;
            default: return ELEMENT_BITS'($urandom);
        endcase
    endfunction

    // Mostly rectangles inside the table; the rest have crossed corners, run
    // past the programmed shape, or are plain random coordinates.
    task automatic ask_random_region();
        int tr;
        int lc;
        int br;
        int rc;
        tr = $urandom_range(0, cur_rows - 1);
        br = $urandom_range(tr, cur_rows - 1);
        lc = $urandom_range(0, cur_cols - 1);
        rc = $urandom_range(lc, cur_cols - 1);
        case ($urandom_range(0, 11))
            0: begin
                tr = $urandom_range(0, COORD_MAX);
                lc = $urandom_range(0, COORD_MAX);
                br = $urandom_range(0, COORD_MAX);
                rc = $urandom_range(0, COORD_MAX);
            end
            1: if (br < COORD_MAX) tr = $urandom_range(br + 1, COORD_MAX);
            2: if (rc < COORD_MAX) lc = $urandom_range(rc + 1, COORD_MAX);
            3: if (cur_rows <= COORD_MAX) br = $urandom_range(cur_rows, COORD_MAX);
            4: if (cur_cols <= COORD_MAX) rc = $urandom_range(cur_cols, COORD_MAX);
            5: begin
                tr = 0;
                lc = 0;
                br = cur_rows - 1;
                rc = cur_cols - 1;
            end
            default: ;
        endcase
        ask_region(tr, lc, br, rc);
    endtask

    // Register value for a wanted dimension: sometimes the out-of-range forms
    // that clamp to it, sometimes with junk above the register bits.
    function automatic logic [PDATA_BITS-1:0] encode_dim(input int dim, input int limit);
        logic [PDATA_BITS-1:0] word;
        word = PDATA_BITS'(dim);
        if (dim == 1 && $urandom_range(0, 2) == 0)
            word = '0;
        else if (dim == limit && $urandom_range(0, 2) == 0)
            word = PDATA_BITS'($urandom_range(limit, (1 << DIM_BITS) - 1));
        if ($urandom_range(0, 7) == 0)
            word[PDATA_BITS-1:DIM_BITS] = (PDATA_BITS-DIM_BITS)'($urandom);
        return word;
    endfunction

    // Setup phase, then access phase; the write lands on the access edge.
    // Back-to-back writes go straight from access into the next setup.
    task automatic write_reg(input logic index, input logic [PDATA_BITS-1:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_BITS'({index, 2'b00});
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic set_dims(input int rows, input int cols,
                            input logic [PDATA_BITS-1:0] rows_word,
                            input logic [PDATA_BITS-1:0] cols_word);
        if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_ROWS, rows_word);
            write_reg(REG_COLS, cols_word);
        end
        else begin
            write_reg(REG_COLS, cols_word);
            write_reg(REG_ROWS, rows_word);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_rows   = rows;
        cur_cols   = cols;
        loads_done = 0;
        shapes_tried++;
    endtask

    // Registers may only change while the block is idle: wait for every owed
    // result, then give a trailing load time to finish its memory write.
    task automatic settle_block();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Raster load of the programmed shape with a few early queries mixed in
    // (those must report an unloaded table), then a round of queries with
    // the odd extra load, which the block drops once the table is full.
    // A partial shape stops loading early, so most of its queries see an
    // unfinished table.
    task automatic fill_and_probe(input bit partial);
        int cells;
        int stop_at;
        int n_queries;
        cells     = cur_rows * cur_cols;
        stop_at   = partial ? $urandom_range(0, cells - 1) : cells;
        n_queries = $urandom_range(6, 24);
        for (int i = 0; i < stop_at; i++) begin
            if ($urandom_range(0, 15) == 0)
                ask_random_region();
            push_element(rand_element());
        end
        ask_region(0, 0, cur_rows - 1, cur_cols - 1);
        for (int i = 0; i < n_queries; i++) begin
            if ($urandom_range(0, 9) == 0)
                push_element(rand_element());
            ask_random_region();
        end
    endtask

    initial
    begin : stimulus
        int rows;
        int cols;
        req_ch.valid         <= 1'b0;
        req_ch.kind          <= KIND_LOAD;
        req_ch.element_value <= '0;
        req_ch.top_row       <= '0;
        req_ch.left_col      <= '0;
        req_ch.bottom_row    <= '0;
        req_ch.right_col     <= '0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        burst_left = $urandom_range(1, MAX_BURST);

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        // Straight out of reset the shape is 256 by 256 and nothing is loaded,
        // so every query reports an unloaded table, crossed corners included.
        ask_region(0, 0, 0, 0);
        ask_region(5, 0, 2, 0);
        push_element(ELEM_MAX);
        push_element(ELEM_MIN);
        push_element('0);
        ask_region(0, 0, 0, 1);

        // A 2 by 3 table holding both element extremes. Writing the registers
        // throws away the partial load above.
        settle_block();
        set_dims(2, 3, 2, 3);
        push_element(ELEM_MIN);
        push_element(ELEM_MAX);
        push_element('0);
        push_element('1);
        push_element(ELEMENT_BITS'(1));
        push_element(ELEM_MIN);
        // The table is full now, so this load must leave it untouched.
        push_element(ELEM_MAX);
        // Whole table, single corner cells, and each mix of the row and
        // column above / left of the rectangle falling off the table.
        ask_region(0, 0, 1, 2);
        ask_region(1, 2, 1, 2);
        ask_region(0, 0, 0, 0);
        ask_region(1, 1, 1, 2);
        ask_region(0, 1, 1, 2);
        ask_region(1, 0, 1, 1);
        // Crossed rows, crossed columns, bottom past the rows, right past the
        // columns, and everything at the top of the coordinate range.
        ask_region(1, 0, 0, 0);
        ask_region(0, 2, 0, 1);
        ask_region(0, 0, 2, 0);
        ask_region(0, 0, 0, 3);
        ask_region(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);

        // Register extremes: zero taken as one row, an oversize value taken as
        // the full width, then the tall single-column shape.
        settle_block();
        set_dims(1, MAX_COLS, '0, PDATA_BITS'((1 << DIM_BITS) - 1));
        fill_and_probe(1'b0);
        settle_block();
        set_dims(MAX_ROWS, 1, PDATA_BITS'(MAX_ROWS), PDATA_BITS'(1));
        fill_and_probe(1'b0);

        // Random shapes, mostly small; a few long thin ones and some loads
        // that are cut short by the next register write.
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 15))
                0: begin
                    rows = $urandom_range(MAX_ROWS / 2, MAX_ROWS);
                    cols = 1;
                end
                1: begin
                    rows = 1;
                    cols = $urandom_range(MAX_COLS / 2, MAX_COLS);
                end
                2: begin
                    rows = 1;
                    cols = 1;
                end
                3: begin
                    rows = $urandom_range(1, 24);
                    cols = $urandom_range(1, 24);
                end
                default: begin
                    rows = $urandom_range(1, 10);
                    cols = $urandom_range(1, 10);
                end
            endcase
            settle_block();
            set_dims(rows, cols, encode_dim(rows, MAX_ROWS), encode_dim(cols, MAX_COLS));
            fill_and_probe($urandom_range(0, 5) == 0);
        end

        // A small table of the most negative element fed without gaps, so the
        // loads follow each other as fast as the block takes them.
        settle_block();
        set_dims(FEED_ROWS, FEED_COLS, encode_dim(FEED_ROWS, MAX_ROWS),
                 encode_dim(FEED_COLS, MAX_COLS));
        steady_feed = 1'b1;
        for (int i = 0; i < FEED_ROWS * FEED_COLS; i++)
            push_element(ELEM_MIN);
        steady_feed = 1'b0;
        ask_region(FEED_ROWS - 1, FEED_COLS - 1, FEED_ROWS - 1, FEED_COLS - 1);
        ask_region(0, 0, FEED_ROWS - 1, FEED_COLS - 1);
        for (int i = 0; i < 30; i++)
            ask_random_region();

        settle_block();
        $display("Run covered %0d items with %0d region queries over %0d table shapes,",
                 items_sent, queries_sent, shapes_tried);
        $display("from a single cell up to %0d rows or %0d columns, ending with a gap-free load.",
                 MAX_ROWS, MAX_COLS);
        if (error_count == 0 && results_owed == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Several times the slowest correct run; reaching it means the block hung.
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d results still owed.", results_owed);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: summed_area_table_region_sum.f
hdl/sat_pkg.sv
hdl/sat_if.sv
hdl/sat_cfg.sv
hdl/sat_mem.sv
hdl/sat_ctrl.sv
hdl/summed_area_table_region_sum.sv
verif/summed_area_table_region_sum_checker.sv
verif/summed_area_table_region_sum_tb.sv
